// File: rtl/fca_pkg.sv
// Shared types and constants for the chained allocation table block.
package fca_pkg;

  localparam int MODE_W   = 1;
  localparam int SIZE_W   = 10;
  localparam int START_W  = 8;
  localparam int FIRST_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 9;
  // Blocks needed by the largest size: ceil(1023 / 4) = 256.
  localparam int NEED_W   = 9;
  localparam int BLOCK_SHIFT = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_START_FREE = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SIZE_W-1:0]  file_size;
    logic [START_W-1:0] start_block;
  } in_req_t;

  typedef struct packed {
    logic [FIRST_W-1:0]  first_block;
    logic [COUNT_W-1:0]  block_count;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live_chains;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LINK_END,
    S_WALK,
    S_RESP
  } ctrl_state_t;

endpackage

// File: rtl/fat_chain_allocator.sv
// Top level: chained allocation table with request/result channels and output register.
// Allocate runs an ascending scan through the table's single read port; free follows the
//   chain one link per read, clearing each entry as it goes.
// Zero-size and no-space rejects answer from the idle state; a free of an empty entry ends
//   at its first read. One request is in work at a time; the output register lets the next
//   request enter while a result waits.
// Reset: a clearing pass writes every table entry free, with in_stall high throughout.
module fat_chain_allocator #(
  parameter int TABLE_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fca_pkg::in_req_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output fca_pkg::out_rsp_t out_data,
  input  logic              out_stall
);

  import fca_pkg::*;

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int EW = AW + 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic          res_valid;
  out_rsp_t      res_data;
  logic          res_take;

  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_data_r, out_data_nxt;

  fca_table_mem #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fca_ctrl #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/fca_table_mem.sv
// Allocation table storage: one write port, one registered read port.
module fca_table_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fca_ctrl.sv
// Request sequencer: scans the table to build chains and walks chains to free them.
module fca_ctrl #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  input  fca_pkg::in_req_t                               in_data,
  output logic                                           in_stall,
  output logic                                           res_valid,
  output fca_pkg::out_rsp_t                              res_data,
  input  logic                                           res_take,
  output logic                                           mem_we,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] mem_waddr,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1):0]   mem_wdata,
  output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] mem_raddr,
  input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1):0]   mem_rdata
);

  import fca_pkg::*;

  localparam int AW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int EW   = AW + 1;
  localparam int CW   = $clog2(TABLE_SIZE + 1);
  localparam int CMPW = (CW > NEED_W) ? CW : NEED_W;

  localparam logic [EW-1:0] ENT_FREE  = '0;
  localparam logic [EW-1:0] ENT_END   = '1;
  localparam logic [EW-1:0] ENT_LIMIT = EW'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(TABLE_SIZE);

  ctrl_state_t       state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     iss_r, iss_nxt;
  logic [AW-1:0]     chk_r, chk_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     prev_r, prev_nxt;
  logic [AW-1:0]     first_r, first_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [NEED_W-1:0] found_r, found_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     free_r, free_nxt;
  logic [CW-1:0]     chains_r, chains_nxt;
  out_rsp_t          res_r, res_nxt;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      pend_r   <= 1'b0;
      free_r   <= CNT_FULL;
      chains_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_r   <= pend_nxt;
      free_r   <= free_nxt;
      chains_r <= chains_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    iss_r   <= iss_nxt;
    chk_r   <= chk_nxt;
    prev_r  <= prev_nxt;
    first_r <= first_nxt;
    need_r  <= need_nxt;
    found_r <= found_nxt;
    cur_r   <= cur_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
  end

  // Next state, table accesses and result
  always_comb begin
    logic [SIZE_W:0]     size_ext;
    logic [NEED_W-1:0]   need_req;
    logic [NEED_W-1:0]   found_inc;
    logic [CW-1:0]       cnt_inc;
    logic [CW:0]         free_sum;
    logic [CW-1:0]       free_rel;
    logic [CW-1:0]       chains_dec;
    logic                walk_stop;

    state_nxt  = state_r;
    clr_nxt    = clr_r;
    iss_nxt    = iss_r;
    chk_nxt    = chk_r;
    pend_nxt   = pend_r;
    prev_nxt   = prev_r;
    first_nxt  = first_r;
    need_nxt   = need_r;
    found_nxt  = found_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    free_nxt   = free_r;
    chains_nxt = chains_r;
    res_nxt    = res_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = ENT_FREE;
    mem_raddr = '0;

    size_ext   = {1'b0, in_data.file_size} + (SIZE_W + 1)'(3);
    need_req   = NEED_W'(size_ext >> BLOCK_SHIFT);
    found_inc  = found_r + NEED_W'(1);
    cnt_inc    = cnt_r + CW'(1);
    free_sum   = {1'b0, free_r} + {1'b0, cnt_r};
    free_rel   = (free_sum > {1'b0, CNT_FULL}) ? CNT_FULL : free_sum[CW-1:0];
    chains_dec = (chains_r != '0) ? (chains_r - CW'(1)) : chains_r;
    walk_stop  = (mem_rdata == ENT_END) || (cnt_inc == CNT_FULL) ||
                 (mem_rdata >= ENT_LIMIT);

    unique case (state_r)
      // Sweep every entry to free after reset
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = ENT_FREE;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // Take a request and reject the trivial cases at once
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_ALLOC) begin
            need_nxt = need_req;
            if (in_data.file_size == '0) begin
              res_nxt   = '{first_block: '0, block_count: '0,
                            status: ST_ZERO_SIZE, live_chains: LIVE_W'(chains_r)};
              state_nxt = S_RESP;
            end else if (CMPW'(need_req) > CMPW'(free_r)) begin
              res_nxt   = '{first_block: '0, block_count: '0,
                            status: ST_NO_SPACE, live_chains: LIVE_W'(chains_r)};
              state_nxt = S_RESP;
            end else begin
              iss_nxt   = '0;
              pend_nxt  = 1'b0;
              found_nxt = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (32'(in_data.start_block) >= 32'(TABLE_SIZE)) begin
              res_nxt   = '{first_block: in_data.start_block, block_count: '0,
                            status: ST_START_FREE, live_chains: LIVE_W'(chains_r)};
              state_nxt = S_RESP;
            end else begin
              mem_raddr = AW'(in_data.start_block);
              cur_nxt   = AW'(in_data.start_block);
              first_nxt = AW'(in_data.start_block);
              cnt_nxt   = '0;
              state_nxt = S_WALK;
            end
          end
        end
      end

      // Stream reads in ascending order; link each free entry to the previous one
      S_SCAN: begin
        mem_raddr = iss_r;
        chk_nxt   = iss_r;
        pend_nxt  = 1'b1;
        if (iss_r != LAST_ADDR) begin
          iss_nxt = iss_r + AW'(1);
        end
        if (pend_r && (mem_rdata == ENT_FREE)) begin
          if (found_r == '0) begin
            first_nxt = chk_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = prev_r;
            mem_wdata = EW'(chk_r);
          end
          prev_nxt  = chk_r;
          found_nxt = found_inc;
          if (found_inc == need_r) begin
            pend_nxt  = 1'b0;
            state_nxt = S_LINK_END;
          end
        end
      end

      // Mark the chain end and commit the allocation
      S_LINK_END: begin
        mem_we     = 1'b1;
        mem_waddr  = prev_r;
        mem_wdata  = ENT_END;
        free_nxt   = free_r - CW'(need_r);
        chains_nxt = chains_r + CW'(1);
        res_nxt    = '{first_block: FIRST_W'(first_r), block_count: COUNT_W'(need_r),
                       status: ST_OK, live_chains: LIVE_W'(chains_r + CW'(1))};
        state_nxt  = S_RESP;
      end

      // Follow links one entry per cycle, clearing as we go
      S_WALK: begin
        if (mem_rdata == ENT_FREE) begin
          if (cnt_r == '0) begin
            res_nxt = '{first_block: FIRST_W'(first_r), block_count: '0,
                        status: ST_START_FREE, live_chains: LIVE_W'(chains_r)};
          end else begin
            free_nxt   = free_rel;
            chains_nxt = chains_dec;
            res_nxt    = '{first_block: FIRST_W'(first_r), block_count: COUNT_W'(cnt_r),
                           status: ST_OK, live_chains: LIVE_W'(chains_dec)};
          end
          state_nxt = S_RESP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_r;
          mem_wdata = ENT_FREE;
          cnt_nxt   = cnt_inc;
          if (walk_stop) begin
            cnt_nxt   = '0;
            free_sum  = {1'b0, free_r} + {1'b0, cnt_inc};
            free_nxt  = (free_sum > {1'b0, CNT_FULL}) ? CNT_FULL : free_sum[CW-1:0];
            chains_nxt = chains_dec;
            res_nxt   = '{first_block: FIRST_W'(first_r), block_count: COUNT_W'(cnt_inc),
                          status: ST_OK, live_chains: LIVE_W'(chains_dec)};
            state_nxt = S_RESP;
          end else begin
            mem_raddr = mem_rdata[AW-1:0];
            cur_nxt   = mem_rdata[AW-1:0];
          end
        end
      end

      // Hold the result until the output register takes it
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res_data  = res_r;

endmodule
